// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/dfd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfd_pkg
// shared constants, types and helpers of the frame departitioner
// ----------------------------------------------------------------------------
package dfd_pkg;

  localparam int CU_VALUES         = 64;
  localparam int SYMBOLS_PER_CIF   = 18;
  localparam int FIC_SYMBOLS       = 3;
  localparam int MAX_SYMBOL_LENGTH = 4096;
  localparam int MIN_SYMBOL_LENGTH = 4;
  localparam int RESET_SYMBOL_LEN  = 3072;

  localparam int LEN_W   = 13;  // symbol length 4..4096
  localparam int POS_W   = 12;  // value index within a symbol or fic block
  localparam int BLEN_W  = 12;  // fic block length up to 3072
  localparam int OFF_W   = 17;  // value offset within a cif, up to 18*4096
  localparam int CIF_W   = 5;   // symbol index within a cif
  localparam int DONE_W  = 2;   // fic symbols done
  localparam int CU_W    = 10;  // capacity unit address or size
  localparam int DATA_W  = 13;  // widest register
  localparam int INDEX_W = 2;
  localparam int VALUE_W = 8;

  // register indexes of the configuration port
  localparam logic [INDEX_W-1:0] REG_SYMBOL_LENGTH = 2'd0;
  localparam logic [INDEX_W-1:0] REG_SUB_ENABLE    = 2'd1;
  localparam logic [INDEX_W-1:0] REG_SUB_START     = 2'd2;
  localparam logic [INDEX_W-1:0] REG_SUB_SIZE      = 2'd3;

  // registered configuration as the router sees it
  typedef struct packed {
    logic [LEN_W-1:0]  len;      // effective symbol length
    logic [BLEN_W-1:0] blen;     // fic block length
    logic [OFF_W-1:0]  lo;       // first subchannel offset
    logic [OFF_W-1:0]  hi;       // subchannel end, clipped to the cif
    logic              sub_on;   // enabled and non-empty
  } cfg_t;

  // router status for checking
  typedef struct packed {
    logic             synced;
    logic             in_fic;
    logic [CIF_W-1:0] cif_position;
  } status_t;

  // clamp to 4..4096 and round down to a multiple of four
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] l;
    l = raw;
    if (l < LEN_W'(MIN_SYMBOL_LENGTH)) l = LEN_W'(MIN_SYMBOL_LENGTH);
    if (l > LEN_W'(MAX_SYMBOL_LENGTH)) l = LEN_W'(MAX_SYMBOL_LENGTH);
    return {l[LEN_W-1:2], 2'b00};
  endfunction

endpackage

// ===== src/dfd_config.sv =====
// ----------------------------------------------------------------------------
// dfd_config
// configuration registers with the derived lengths and subchannel bounds
// ----------------------------------------------------------------------------
module dfd_config (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [dfd_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [dfd_pkg::DATA_W-1:0]    cfg_data,
  output dfd_pkg::cfg_t                 cfg
);

  logic [dfd_pkg::LEN_W-1:0] symbol_length, symbol_length_next;
  logic                      sub_enable, sub_enable_next;
  logic [dfd_pkg::CU_W-1:0]  sub_start, sub_start_next;
  logic [dfd_pkg::CU_W-1:0]  sub_size, sub_size_next;
  dfd_pkg::cfg_t             cfg_next;
  logic [dfd_pkg::OFF_W-1:0] cif_len;
  logic [dfd_pkg::OFF_W-1:0] hi_raw;

  always_comb begin
    symbol_length_next = symbol_length;
    sub_enable_next    = sub_enable;
    sub_start_next     = sub_start;
    sub_size_next      = sub_size;
    if (rst) begin
      symbol_length_next = dfd_pkg::LEN_W'(dfd_pkg::RESET_SYMBOL_LEN);
      sub_enable_next    = 1'b0;
      sub_start_next     = '0;
      sub_size_next      = '0;
    end else if (cfg_write) begin
      case (cfg_index)
        dfd_pkg::REG_SYMBOL_LENGTH: symbol_length_next = dfd_pkg::eff_len(cfg_data);
        dfd_pkg::REG_SUB_ENABLE:    sub_enable_next    = cfg_data[0];
        dfd_pkg::REG_SUB_START:     sub_start_next     = cfg_data[dfd_pkg::CU_W-1:0];
        dfd_pkg::REG_SUB_SIZE:      sub_size_next      = cfg_data[dfd_pkg::CU_W-1:0];
        default: ;
      endcase
    end
  end

  // derived values follow the next register values so they are current
  // on the cycle right after a write
  always_comb begin
    cif_len = dfd_pkg::OFF_W'(dfd_pkg::SYMBOLS_PER_CIF) *
              dfd_pkg::OFF_W'(symbol_length_next);
    hi_raw  = dfd_pkg::OFF_W'(dfd_pkg::CU_VALUES) *
              (dfd_pkg::OFF_W'(sub_start_next) + dfd_pkg::OFF_W'(sub_size_next));
    cfg_next.len  = symbol_length_next;
    cfg_next.blen = dfd_pkg::BLEN_W'(dfd_pkg::FIC_SYMBOLS *
                    int'(symbol_length_next[dfd_pkg::LEN_W-1:2]));
    cfg_next.lo   = dfd_pkg::OFF_W'(dfd_pkg::CU_VALUES) *
                    dfd_pkg::OFF_W'(sub_start_next);
    cfg_next.hi   = (hi_raw > cif_len) ? cif_len : hi_raw;
    cfg_next.sub_on = sub_enable_next && (cfg_next.lo < cfg_next.hi);
  end

  always_ff @(posedge clk) begin
    symbol_length <= symbol_length_next;
    sub_enable    <= sub_enable_next;
    sub_start     <= sub_start_next;
    sub_size      <= sub_size_next;
    cfg           <= cfg_next;
  end

endmodule

// ===== src/dfd_router.sv =====
// ----------------------------------------------------------------------------
// dfd_router
// input register, frame counters and result register
// ----------------------------------------------------------------------------
module dfd_router (
  input  logic                         clk,
  input  logic                         rst,
  input  dfd_pkg::cfg_t                cfg,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic signed [dfd_pkg::VALUE_W-1:0] soft_value,
  input  logic                         frame_sync,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         channel,
  output logic signed [dfd_pkg::VALUE_W-1:0] value_out,
  output logic [1:0]                   fic_block,
  output logic                         first_of_run,
  output logic                         last_of_run,
  output dfd_pkg::status_t             status
);

  // input register
  logic                                hold_valid;
  logic signed [dfd_pkg::VALUE_W-1:0]  hold_value;
  logic                                hold_sync;

  // frame state
  logic                          synced, synced_next;
  logic                          in_fic, in_fic_next;
  logic [1:0]                    fic_index, fic_index_next;
  logic [dfd_pkg::POS_W-1:0]     fic_pos, fic_pos_next;
  logic [dfd_pkg::DONE_W-1:0]    fic_done, fic_done_next;
  logic [dfd_pkg::POS_W-1:0]     sym_pos, sym_pos_next;
  logic [dfd_pkg::CIF_W-1:0]     cif_pos, cif_pos_next;

  // values after a sync restart
  logic                          cur_fic;
  logic [1:0]                    cur_index;
  logic [dfd_pkg::POS_W-1:0]     cur_fic_pos;
  logic [dfd_pkg::DONE_W-1:0]    cur_done;
  logic [dfd_pkg::POS_W-1:0]     cur_sym_pos;
  logic [dfd_pkg::CIF_W-1:0]     cur_cif;

  logic                          can_load, fire, active;
  logic                          blk_last, sym_last;
  logic [dfd_pkg::DONE_W:0]      done_inc;
  logic [dfd_pkg::CIF_W-1:0]     cif_inc;
  logic [dfd_pkg::OFF_W-1:0]     off;
  logic                          in_run;
  logic                          produce;
  logic                          res_channel, res_first, res_last;

  assign can_load   = !result_valid || !result_stall;
  assign fire       = hold_valid && can_load;
  assign item_stall = hold_valid && !can_load;

  always_comb begin
    cur_fic     = hold_sync ? 1'b1 : in_fic;
    cur_index   = hold_sync ? '0 : fic_index;
    cur_fic_pos = hold_sync ? '0 : fic_pos;
    cur_done    = hold_sync ? '0 : fic_done;
    cur_sym_pos = hold_sync ? '0 : sym_pos;
    cur_cif     = hold_sync ? '0 : cif_pos;
    active      = hold_sync || synced;

    blk_last = ({1'b0, cur_fic_pos} + 1'b1) >= {1'b0, cfg.blen};
    sym_last = ({1'b0, cur_sym_pos} + 1'b1) >= cfg.len;
    done_inc = {1'b0, cur_done} + 1'b1;
    cif_inc  = cur_cif + 1'b1;

    off    = dfd_pkg::OFF_W'(cur_cif) * dfd_pkg::OFF_W'(cfg.len) +
             dfd_pkg::OFF_W'(cur_sym_pos);
    in_run = cfg.sub_on && (off >= cfg.lo) && (off < cfg.hi);

    produce     = active && (cur_fic || in_run);
    res_channel = !cur_fic;
    res_first   = !cur_fic && (off == cfg.lo);
    res_last    = cur_fic ? blk_last : (dfd_pkg::OFF_W'(off + 1'b1) == cfg.hi);

    synced_next    = active;
    in_fic_next    = cur_fic;
    fic_index_next = cur_index;
    fic_pos_next   = cur_fic_pos;
    fic_done_next  = cur_done;
    sym_pos_next   = cur_sym_pos;
    cif_pos_next   = cur_cif;

    if (cur_fic) begin
      if (blk_last) begin
        fic_pos_next   = '0;
        fic_index_next = cur_index + 1'b1;
      end else begin
        fic_pos_next = cur_fic_pos + 1'b1;
      end
    end

    if (sym_last) begin
      sym_pos_next = '0;
      if (cur_fic) begin
        fic_done_next = done_inc[dfd_pkg::DONE_W-1:0];
        if (done_inc >= (dfd_pkg::DONE_W+1)'(dfd_pkg::FIC_SYMBOLS)) begin
          in_fic_next    = 1'b0;
          fic_done_next  = '0;
          fic_index_next = '0;
          fic_pos_next   = '0;
          cif_pos_next   = '0;
        end
      end else begin
        cif_pos_next = (cif_inc >= dfd_pkg::CIF_W'(dfd_pkg::SYMBOLS_PER_CIF)) ? '0 : cif_inc;
      end
    end else begin
      sym_pos_next = cur_sym_pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
      synced       <= 1'b0;
      in_fic       <= 1'b0;
      fic_index    <= '0;
      fic_pos      <= '0;
      fic_done     <= '0;
      sym_pos      <= '0;
      cif_pos      <= '0;
    end else begin
      if (!item_stall) begin
        hold_valid <= item_valid;
      end
      if (can_load) begin
        result_valid <= fire && produce;
      end
      // values before the first sync leave the counters alone
      if (fire && active) begin
        synced    <= synced_next;
        in_fic    <= in_fic_next;
        fic_index <= fic_index_next;
        fic_pos   <= fic_pos_next;
        fic_done  <= fic_done_next;
        sym_pos   <= sym_pos_next;
        cif_pos   <= cif_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold_value <= soft_value;
      hold_sync  <= frame_sync;
    end
    if (fire && produce) begin
      channel      <= res_channel;
      value_out    <= hold_value;
      fic_block    <= cur_fic ? cur_index : 2'd0;
      first_of_run <= res_first;
      last_of_run  <= res_last;
    end
  end

  assign status.synced       = synced;
  assign status.in_fic       = in_fic;
  assign status.cif_position = cif_pos;

endmodule

// ===== src/dab_frame_departitioner.sv =====
// a value taken into the input register moves on to the result register once that register can load
// throughput: one soft value per cycle; the input register holds while the result is stalled
// a value outside the fic and the selected subchannel, or before the first sync, gives no result
// reset (rst, synchronous): counters and valids clear, symbol length 3072, subchannel off
// ----------------------------------------------------------------------------
// dab_frame_departitioner
// routes soft values of a transmission frame to fic blocks and one subchannel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dab_frame_departitioner (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [dfd_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [dfd_pkg::DATA_W-1:0]          cfg_data,
  // soft value stream
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic signed [dfd_pkg::VALUE_W-1:0]  soft_value,
  input  logic                                frame_sync,
  // routed values
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                channel,
  output logic signed [dfd_pkg::VALUE_W-1:0]  value_out,
  output logic [1:0]                          fic_block,
  output logic                                first_of_run,
  output logic                                last_of_run
);

  dfd_pkg::cfg_t    cfg;
  dfd_pkg::status_t status;

  // register file; derived bounds are ready the cycle after a write
  dfd_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register -> counters and compares -> result register
  dfd_router u_router (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .soft_value   (soft_value),
    .frame_sync   (frame_sync),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .channel      (channel),
    .value_out    (value_out),
    .fic_block    (fic_block),
    .first_of_run (first_of_run),
    .last_of_run  (last_of_run),
    .status       (status)
  );

  // subchannel values carry no fic block number
  `ASSERT_IMPLIES(a_sub_block_zero, clk, rst, result_valid && channel, fic_block == 2'd0)
  // fic values never open a subchannel run
  `ASSERT_IMPLIES(a_fic_not_first, clk, rst, result_valid && !channel, !first_of_run)
  // nothing leaves before the first sync has been taken
  `ASSERT_IMPLIES(a_out_after_sync, clk, rst, result_valid, status.synced)
  // the cif counter rests at zero while the fic passes
  `ASSERT_IMPLIES(a_fic_cif_zero, clk, rst, status.in_fic, status.cif_position == '0)

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the frame departitioner against a cycle-free routing model: soft
// values are sent as sync-led frames with random content under a series of
// register settings, and every routed value is compared field by field
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD   = 400;     // receiver hold-off, in cycles
  localparam int CYCLE_LIMIT = 400000;  // run is far shorter than this
  localparam int TAIL_CYCLES = 6;       // margin for the pipeline tail after the drain

  // one soft value transfer on the input side
  typedef struct {
    logic signed [dfd_pkg::VALUE_W-1:0] value;
    logic                               sync;
  } soft_item_t;

  // one routed value on the output side
  typedef struct {
    logic                               ch;
    logic signed [dfd_pkg::VALUE_W-1:0] value;
    logic [1:0]                         blk;
    logic                               first;
    logic                               last;
  } route_t;

  // ports of the block; the inputs are known from time zero
  logic                               clk          = 1'b0;
  logic                               rst          = 1'b1;
  logic                               cfg_write    = 1'b0;
  logic [dfd_pkg::INDEX_W-1:0]        cfg_index    = '0;
  logic [dfd_pkg::DATA_W-1:0]         cfg_data     = '0;
  logic                               item_valid   = 1'b0;
  logic                               item_stall;
  logic signed [dfd_pkg::VALUE_W-1:0] soft_value   = '0;
  logic                               frame_sync   = 1'b0;
  logic                               result_valid;
  logic                               result_stall = 1'b0;
  logic                               channel;
  logic signed [dfd_pkg::VALUE_W-1:0] value_out;
  logic [1:0]                         fic_block;
  logic                               first_of_run;
  logic                               last_of_run;

  dab_frame_departitioner DUT (.*);

  // stimulus and scoreboard storage
  soft_item_t  values_to_send[$];
  route_t      routes_due[$];
  int unsigned values_queued = 0;
  int unsigned values_taken  = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  // idling control, set between phases at the falling edge
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit long_hold_req  = 1'b0;
  bit hold_taken     = 1'b0;
  int hold_left      = 0;

  // routing model: register copies
  logic [dfd_pkg::LEN_W-1:0] len_reg   = dfd_pkg::LEN_W'(dfd_pkg::RESET_SYMBOL_LEN);
  logic                      en_reg    = 1'b0;
  logic [dfd_pkg::CU_W-1:0]  start_reg = '0;
  logic [dfd_pkg::CU_W-1:0]  size_reg  = '0;

  // routing model: frame position state
  logic        synced_q  = 1'b0;
  logic        in_fic_q  = 1'b0;
  logic [1:0]  fic_blk_q = '0;
  logic [11:0] fic_pos_q = '0;
  logic [1:0]  fic_sym_q = '0;
  logic [11:0] sym_pos_q = '0;
  logic [15:0] cif_sym_q = '0;

  soft_item_t send_item;
  soft_item_t taken_item;
  route_t     routed;
  route_t     due;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // symbol length as the router uses it: clamped, then a multiple of four
  function automatic int unsigned usable_len(input logic [dfd_pkg::LEN_W-1:0] raw);
    int unsigned l;
    l = raw;
    if (l < dfd_pkg::MIN_SYMBOL_LENGTH) l = dfd_pkg::MIN_SYMBOL_LENGTH;
    if (l > dfd_pkg::MAX_SYMBOL_LENGTH) l = dfd_pkg::MAX_SYMBOL_LENGTH;
    return l - (l % 4);
  endfunction

  // advance the frame state by one soft value; returns 1 when it is routed
  function automatic bit route_value(input soft_item_t it, output route_t r);
    int unsigned len, blen, cif_len, off, lo, hi;
    bit          hit, last;
    len = usable_len(len_reg);
    hit = 1'b0;
    if (it.sync) begin
      // a sync restarts the frame at this very value
      synced_q  = 1'b1;
      in_fic_q  = 1'b1;
      fic_blk_q = '0;
      fic_pos_q = '0;
      fic_sym_q = '0;
      sym_pos_q = '0;
      cif_sym_q = '0;
    end else if (!synced_q) begin
      // nothing routed before the first sync
      return 1'b0;
    end

    if (in_fic_q) begin
      blen    = dfd_pkg::FIC_SYMBOLS * len / 4;
      last    = (fic_pos_q + 32'd1 >= blen);
      r.ch    = 1'b0;
      r.value = it.value;
      r.blk   = fic_blk_q;
      r.first = 1'b0;
      r.last  = last;
      hit     = 1'b1;
      if (last) begin
        fic_pos_q = '0;
        fic_blk_q = fic_blk_q + 2'd1;
      end else begin
        fic_pos_q = fic_pos_q + 12'd1;
      end
    end else begin
      // subchannel window within the cif, clipped to its end
      cif_len = dfd_pkg::SYMBOLS_PER_CIF * len;
      off     = cif_sym_q * len + sym_pos_q;
      lo      = start_reg;
      lo      = lo * dfd_pkg::CU_VALUES;
      hi      = start_reg;
      hi      = (hi + size_reg) * dfd_pkg::CU_VALUES;
      if (hi > cif_len) hi = cif_len;
      if (en_reg && lo < hi && off >= lo && off < hi) begin
        r.ch    = 1'b1;
        r.value = it.value;
        r.blk   = '0;
        r.first = (off == lo);
        r.last  = (off + 32'd1 == hi);
        hit     = 1'b1;
      end
    end

    // symbol and cif counters, compared with >= so a shorter length still wraps
    if (sym_pos_q + 32'd1 >= len) begin
      sym_pos_q = '0;
      if (in_fic_q) begin
        fic_sym_q = fic_sym_q + 2'd1;
        if (fic_sym_q >= dfd_pkg::FIC_SYMBOLS) begin
          in_fic_q  = 1'b0;
          fic_sym_q = '0;
          fic_blk_q = '0;
          fic_pos_q = '0;
          cif_sym_q = '0;
        end
      end else begin
        cif_sym_q = cif_sym_q + 16'd1;
        if (cif_sym_q >= dfd_pkg::SYMBOLS_PER_CIF) cif_sym_q = '0;
      end
    end else begin
      sym_pos_q = sym_pos_q + 12'd1;
    end
    return hit;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // register write; the model copy follows the write edge
  task automatic write_reg(input logic [dfd_pkg::INDEX_W-1:0] idx,
                           input logic [dfd_pkg::DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      dfd_pkg::REG_SYMBOL_LENGTH: len_reg   = val;
      dfd_pkg::REG_SUB_ENABLE:    en_reg    = val[0];
      dfd_pkg::REG_SUB_START:     start_reg = val[dfd_pkg::CU_W-1:0];
      dfd_pkg::REG_SUB_SIZE:      size_reg  = val[dfd_pkg::CU_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_routing(input int raw_len, input int en, input int start,
                             input int size);
    write_reg(dfd_pkg::REG_SYMBOL_LENGTH, dfd_pkg::DATA_W'(raw_len));
    write_reg(dfd_pkg::REG_SUB_ENABLE, dfd_pkg::DATA_W'(en));
    write_reg(dfd_pkg::REG_SUB_START, dfd_pkg::DATA_W'(start));
    write_reg(dfd_pkg::REG_SUB_SIZE, dfd_pkg::DATA_W'(size));
    @(negedge clk);
  endtask

  task automatic push_item(input logic [7:0] v, input logic s);
    soft_item_t it;
    it.value = v;
    it.sync  = s;
    values_to_send.push_back(it);
    values_queued++;
  endtask

  // sync-led frames with random content; some cut short, a few stray syncs
  task automatic load_frames(input int n);
    int unsigned len, frame, k;
    int          left;
    len  = usable_len(len_reg);
    left = n;
    while (left > 0) begin
      if ($urandom_range(9) == 0)
        frame = $urandom_range(1, dfd_pkg::FIC_SYMBOLS * len);
      else
        frame = dfd_pkg::FIC_SYMBOLS * len +
                $urandom_range(0, 2 * dfd_pkg::SYMBOLS_PER_CIF * len);
      if (frame > left) frame = left;
      for (k = 0; k < frame; k++)
        push_item(8'($urandom_range(0, 255)), (k == 0) || ($urandom_range(49) == 0));
      left -= frame;
    end
  endtask

  // everything sent has been taken and routed, plus the pipeline tail
  task automatic wait_drained;
    while (values_taken != values_queued || routes_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int send_idle, input int recv_stall, input int raw_len,
                           input int en, input int start, input int size, input int n,
                           input bit hold);
    wait_drained;
    set_routing(raw_len, en, start, size);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    load_frames(n);
    // long receiver hold-off while the sender keeps offering
    if (hold) long_hold_req = 1'b1;
  endtask

  // input driver: next value only once the current one is transferred
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (values_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        send_item = values_to_send.pop_front();
        item_valid <= 1'b1;
        soft_value <= send_item.value;
        frame_sync <= send_item.sync;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // output stall: random, or a long hold-off counted here
  always @(posedge clk) begin
    if (long_hold_req && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_left    <= LONG_HOLD;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: check routed values, then predict from the input transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (routes_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual ch %b value %h",
                   $time, channel, value_out);
          mismatches++;
        end else begin
          due = routes_due.pop_front();
          check_field("channel", due.ch, channel);
          check_field("value_out", due.value, value_out);
          check_field("fic_block", due.blk, fic_block);
          check_field("first_of_run", due.first, first_of_run);
          check_field("last_of_run", due.last, last_of_run);
        end
      end
      if (item_valid && !item_stall) begin
        taken_item.value = soft_value;
        taken_item.sync  = frame_sync;
        values_taken++;
        if (route_value(taken_item, routed)) routes_due.push_back(routed);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[dab_frame_departitioner] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender idles rarely, receiver stalls often
    send_idle_pct  = 7;
    recv_stall_pct = 76;

    // reset settings: values before the first sync are dropped,
    // then the start of fic block 0 with the extreme values
    push_item(8'h7f, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h80, 1'b1);
    push_item(8'h7f, 1'b0);
    push_item(8'hff, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h55, 1'b0);
    push_item(8'haa, 1'b0);

    // length below range changed mid-frame, then a sync while synced
    wait_drained;
    set_routing(0, 1, 1, 1);
    push_item(8'h01, 1'b0);
    push_item(8'hfe, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h7f, 1'b1);
    repeat (11) push_item(8'($urandom_range(0, 255)), 1'b0);

    // run clipped to the cif end shows up with lengths 4 and 8
    run_phase(7, 76, 0, 1, 0, 1, 160, 1'b0);
    run_phase(7, 76, 5, 1, 1, 5, 150, 1'b0);
    run_phase(7, 76, 8, 1, 2, 1, 150, 1'b0);

    // sender idles often, receiver stalls rarely; disabled and empty subchannels
    run_phase(76, 7, 16, 1, 1, 2, 160, 1'b0);
    run_phase(76, 7, 17, 0, 0, 864, 70, 1'b0);
    run_phase(76, 7, 12, 1, 0, 0, 70, 1'b0);
    run_phase(76, 7, $urandom_range(0, 40), $urandom_range(0, 1), $urandom_range(0, 4),
              $urandom_range(0, 5), 60, 1'b0);
    run_phase(76, 7, $urandom_range(0, 40), $urandom_range(0, 1), $urandom_range(0, 4),
              $urandom_range(0, 5), 60, 1'b0);

    // no idling; whole-cif subchannel with the long hold-off to back up the input
    run_phase(0, 0, 8, 1, 0, 1023, 160, 1'b1);
    // length above range and the largest lengths, only a short stretch of fic
    run_phase(0, 0, 8191, 1, 1023, 1023, 60, 1'b0);
    run_phase(0, 0, 4096, 1, 863, 864, 40, 1'b0);
    run_phase(0, 0, 3, 1, 1, 1, 70, 1'b0);
    run_phase(0, 0, $urandom_range(0, 40), $urandom_range(0, 1), $urandom_range(0, 4),
              $urandom_range(0, 5), 60, 1'b0);

    wait_drained;
    if (mismatches == 0) begin
      $display("[dab_frame_departitioner] OK");
    end else begin
      $display("[dab_frame_departitioner] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/dfd_pkg.sv
src/dfd_config.sv
src/dfd_router.sv
src/dab_frame_departitioner.sv
test/tb.sv
